// File: hdl/assert_macros.svh
// Assertion macros for the RTL, included by the top-level parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: hdl/tsp_pkg.sv
// Types and constants of the transport stream packet header parser.
`default_nettype none

package tsp_pkg;

  localparam int unsigned PacketBytes = 188;
  localparam int unsigned PidCount    = 8192;
  localparam int unsigned PidW        = $clog2(PidCount);
  localparam int unsigned ClassW      = 2;

  localparam logic [7:0] SyncByte    = 8'h47;
  localparam logic [7:0] MaxAdaptLen = 8'd183;
  localparam logic [7:0] FullPayload = 8'd184;
  localparam logic [7:0] LastPos     = 8'(PacketBytes - 1);
  localparam logic [7:0] PosFlags    = 8'd1;
  localparam logic [7:0] PosPidLow   = 8'd2;
  localparam logic [7:0] PosCtrl     = 8'd3;
  localparam logic [7:0] PosAdaptLen = 8'd4;

  localparam logic [PidW-1:0] PidPat  = 13'h0000;
  localparam logic [PidW-1:0] PidCat  = 13'h0001;
  localparam logic [PidW-1:0] PidTsdt = 13'h0002;
  localparam logic [PidW-1:0] PidIpmp = 13'h0003;
  localparam logic [PidW-1:0] PidSdt  = 13'h0011;
  localparam logic [PidW-1:0] PidNull = 13'h1fff;

  localparam logic [ClassW-1:0] ClsUnknown = 2'd0;
  localparam logic [ClassW-1:0] ClsPsi     = 2'd1;
  localparam logic [ClassW-1:0] ClsPes     = 2'd2;

  localparam logic [1:0] AfcNone    = 2'd0;
  localparam logic [1:0] AfcPayload = 2'd1;
  localparam logic [1:0] AfcField   = 2'd2;
  localparam logic [1:0] AfcBoth    = 2'd3;

  typedef enum logic {
    CmdByte  = 1'b0,
    CmdTable = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindHeader   = 2'd1,
    KindBadSync  = 2'd2,
    KindBadAdapt = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RouteDrop = 2'd0,
    RoutePsi  = 2'd1,
    RoutePes  = 2'd2
  } route_e;

  typedef struct packed {
    cmd_e              command;
    logic [7:0]        stream_byte;
    logic [PidW-1:0]   table_pid;
    logic [ClassW-1:0] table_class;
  } in_item_t;

  typedef struct packed {
    kind_e           kind;
    logic [PidW-1:0] packet_pid;
    logic            unit_start;
    logic            error_flag;
    logic [1:0]      scramble_bits;
    logic [1:0]      field_control;
    logic [3:0]      continuity;
    logic [7:0]      payload_length;
    logic [1:0]      route;
    logic            control_warning;
    logic [7:0]      payload_byte;
    logic            last_of_packet;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/tsp_in_if.sv
// Input channel: stream bytes and table write commands.
`default_nettype none

interface tsp_in_if;
  logic               valid;
  logic               ready;
  tsp_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tsp_out_if.sv
// Output channel: header summaries, errors and routed payload bytes.
`default_nettype none

interface tsp_out_if;
  logic               valid;
  logic               ready;
  tsp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ts_packet_header_parser.sv
// Transport stream packet header parser, top level.
//
// in_i carries one transfer per cycle: a stream byte (command byte) or a write
// of one entry of the PID class table (command table). Stream bytes form
// 188-byte packets; the parser checks the sync byte, takes the header fields,
// skips the adaptation field and emits a header summary, then each payload
// byte with its route (dropped, PSI, PES). Bad sync or a bad adaptation length
// gives an error transfer and silences the rest of that packet.
// out_o carries at most one result per accepted input, registered: it appears
// the cycle after the input transfer. Throughput is one input per cycle; the
// class of the packet's PID is read from the 8192 x 2 table RAM when the
// second PID byte arrives, and is ready for the control byte that follows.
// After reset the table is cleared one entry per cycle: in_i.ready stays low
// until all 8192 entries are clear. When out_o stalls, the result holds in
// the output register and in_i.ready drops until it is taken; a new input is
// taken in the same cycle that a waiting result is transferred.
`default_nettype none
`include "assert_macros.svh"

module ts_packet_header_parser (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tsp_in_if.sink    in_i,
  tsp_out_if.source out_o
);

  localparam int unsigned PidW   = tsp_pkg::PidW;
  localparam int unsigned ClassW = tsp_pkg::ClassW;

  logic              clr_busy_q;
  logic [PidW-1:0]   clr_cnt_q;

  logic [7:0]        pos_q, pos_d;
  logic [PidW-1:0]   pid_q, pid_d;
  logic [7:0]        hdr_q, hdr_d;
  logic [7:0]        skip_q, skip_d;
  logic [1:0]        route_q, route_d;
  logic              discard_q, discard_d;
  logic              tei_q, tei_d;
  logic              pusi_q, pusi_d;
  logic              warn_q, warn_d;
  logic [7:0]        paylen_q, paylen_d;
  logic              body_q, body_d;
  logic [ClassW-1:0] cls_q, cls_d;
  logic              rd_pend_q, rd_pend_d;

  logic              out_valid_q;
  tsp_pkg::out_item_t out_q, res;

  logic              in_acc;
  logic              emit;
  tsp_pkg::kind_e    kind_v;
  logic [7:0]        data_v;
  logic              last_v;
  logic              finish;
  logic              done;
  logic [1:0]        afc_v;
  logic [7:0]        skip_v;
  logic [ClassW-1:0] cls_v;
  logic [7:0]        b;

  logic              tw_we;
  logic [PidW-1:0]   tw_addr;
  logic [ClassW-1:0] tw_data;
  logic              ram_we;
  logic [PidW-1:0]   ram_waddr;
  logic [ClassW-1:0] ram_wdata;
  logic              ram_re;
  logic [PidW-1:0]   ram_raddr;
  logic [ClassW-1:0] ram_rdata;

  assign in_i.ready = !clr_busy_q && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.data.stream_byte;

  always_comb begin
    pos_d     = pos_q;
    pid_d     = pid_q;
    hdr_d     = hdr_q;
    skip_d    = skip_q;
    route_d   = route_q;
    discard_d = discard_q;
    tei_d     = tei_q;
    pusi_d    = pusi_q;
    warn_d    = warn_q;
    paylen_d  = paylen_q;
    body_d    = body_q;
    cls_d     = rd_pend_q ? ram_rdata : cls_q;
    cls_v     = cls_d;
    rd_pend_d = 1'b0;
    emit      = 1'b0;
    kind_v    = tsp_pkg::KindHeader;
    data_v    = 8'd0;
    last_v    = 1'b0;
    finish    = 1'b0;
    done      = 1'b0;
    afc_v     = hdr_q[5:4];
    skip_v    = (skip_q != 8'd0) ? skip_q - 8'd1 : skip_q;
    tw_we     = 1'b0;
    tw_addr   = in_i.data.table_pid;
    tw_data   = in_i.data.table_class;
    ram_re    = 1'b0;
    ram_raddr = {pid_q[PidW-1:8], b};

    if (in_acc) begin
      if (in_i.data.command == tsp_pkg::CmdTable) begin
        tw_we = 1'b1;
        if (in_i.data.table_pid == pid_q) begin
          cls_d = in_i.data.table_class;
        end
      end else begin
        if (pos_q == 8'd0) begin
          pid_d     = '0;
          hdr_d     = 8'd0;
          skip_d    = 8'd0;
          route_d   = tsp_pkg::RouteDrop;
          tei_d     = 1'b0;
          pusi_d    = 1'b0;
          warn_d    = 1'b0;
          paylen_d  = 8'd0;
          body_d    = 1'b0;
          discard_d = 1'b0;
          if (b != tsp_pkg::SyncByte) begin
            emit      = 1'b1;
            kind_v    = tsp_pkg::KindBadSync;
            discard_d = 1'b1;
          end
        end else if (!discard_q) begin
          if (pos_q == tsp_pkg::PosFlags) begin
            tei_d  = b[7];
            pusi_d = b[6];
            pid_d  = {b[4:0], 8'd0};
          end else if (pos_q == tsp_pkg::PosPidLow) begin
            pid_d = {pid_q[PidW-1:8], b};
            if (pid_d == tsp_pkg::PidPat || pid_d == tsp_pkg::PidCat ||
                pid_d == tsp_pkg::PidTsdt || pid_d == tsp_pkg::PidIpmp ||
                pid_d == tsp_pkg::PidSdt) begin
              tw_we   = 1'b1;
              tw_addr = pid_d;
              tw_data = tsp_pkg::ClsPsi;
              cls_d   = tsp_pkg::ClsPsi;
            end else begin
              ram_re    = 1'b1;
              rd_pend_d = 1'b1;
            end
          end else if (pos_q == tsp_pkg::PosCtrl) begin
            hdr_d = b;
            afc_v = b[5:4];
            if (afc_v == tsp_pkg::AfcNone || afc_v == tsp_pkg::AfcPayload) begin
              paylen_d = (afc_v == tsp_pkg::AfcPayload) ? tsp_pkg::FullPayload : 8'd0;
              finish   = 1'b1;
            end
          end else if (!body_q) begin
            if (pos_q == tsp_pkg::PosAdaptLen) begin
              if (b > tsp_pkg::MaxAdaptLen) begin
                emit      = 1'b1;
                kind_v    = tsp_pkg::KindBadAdapt;
                discard_d = 1'b1;
              end else if (b == 8'd0) begin
                done = 1'b1;
              end else begin
                skip_d = b;
              end
            end else begin
              skip_d = skip_v;
              done   = (skip_v == 8'd0);
            end
            if (done) begin
              paylen_d = (afc_v == tsp_pkg::AfcBoth && pos_q < tsp_pkg::LastPos) ?
                         tsp_pkg::LastPos - pos_q : 8'd0;
              finish   = 1'b1;
            end
          end else if (paylen_q != 8'd0) begin
            emit   = 1'b1;
            kind_v = tsp_pkg::KindPayload;
            data_v = b;
            last_v = (pos_q == tsp_pkg::LastPos);
          end
        end
        pos_d = (pos_q >= tsp_pkg::LastPos) ? 8'd0 : pos_q + 8'd1;
      end
    end

    if (finish) begin
      emit   = 1'b1;
      kind_v = tsp_pkg::KindHeader;
      if (pid_d == tsp_pkg::PidNull) begin
        route_d = tsp_pkg::RouteDrop;
      end else if (cls_v == tsp_pkg::ClsPsi) begin
        route_d = tsp_pkg::RoutePsi;
      end else if (cls_v == tsp_pkg::ClsPes) begin
        route_d = tsp_pkg::RoutePes;
      end else if (pid_d == tsp_pkg::PidPat || pid_d == tsp_pkg::PidCat ||
                   pid_d == tsp_pkg::PidTsdt || pid_d == tsp_pkg::PidSdt) begin
        route_d = tsp_pkg::RoutePsi;
      end else begin
        route_d = tsp_pkg::RouteDrop;
      end
      warn_d = (cls_v == tsp_pkg::ClsPes) &&
               (afc_v == tsp_pkg::AfcNone || afc_v == tsp_pkg::AfcBoth);
      body_d = 1'b1;
    end
  end

  always_comb begin
    res.kind            = kind_v;
    res.packet_pid      = pid_d;
    res.unit_start      = pusi_d;
    res.error_flag      = tei_d;
    res.scramble_bits   = hdr_d[7:6];
    res.field_control   = hdr_d[5:4];
    res.continuity      = hdr_d[3:0];
    res.payload_length  = paylen_d;
    res.route           = route_d;
    res.control_warning = warn_d;
    res.payload_byte    = data_v;
    res.last_of_packet  = last_v;
  end

  // table port: clear sweep after reset, else command or fixed-PID write
  assign ram_we    = clr_busy_q || tw_we;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : tw_addr;
  assign ram_wdata = clr_busy_q ? tsp_pkg::ClsUnknown : tw_data;

  tsp_ram #(
    .Width (ClassW),
    .Depth (tsp_pkg::PidCount)
  ) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == PidW'(tsp_pkg::PidCount - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 8'd0;
      pid_q     <= '0;
      hdr_q     <= 8'd0;
      skip_q    <= 8'd0;
      route_q   <= tsp_pkg::RouteDrop;
      discard_q <= 1'b0;
      tei_q     <= 1'b0;
      pusi_q    <= 1'b0;
      warn_q    <= 1'b0;
      paylen_q  <= 8'd0;
      body_q    <= 1'b0;
      cls_q     <= tsp_pkg::ClsUnknown;
      rd_pend_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      pid_q     <= pid_d;
      hdr_q     <= hdr_d;
      skip_q    <= skip_d;
      route_q   <= route_d;
      discard_q <= discard_d;
      tei_q     <= tei_d;
      pusi_q    <= pusi_d;
      warn_q    <= warn_d;
      paylen_q  <= paylen_d;
      body_q    <= body_d;
      cls_q     <= cls_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `ASSERT_IMPL(a_no_accept_while_clearing, clr_busy_q, !in_i.ready)
  `ASSERT_IMPL(a_result_needs_byte, $rose(out_valid_q),
               $past(in_acc && in_i.data.command == tsp_pkg::CmdByte))
  `ASSERT_IMPL(a_read_before_ctrl, rd_pend_q, pos_q == tsp_pkg::PosCtrl)
  `ASSERT_IMPL(a_payload_has_length,
               out_valid_q && out_q.kind == tsp_pkg::KindPayload,
               out_q.payload_length != 8'd0)
  `ASSERT_IMPL(a_last_only_on_payload, out_valid_q && out_q.last_of_packet,
               out_q.kind == tsp_pkg::KindPayload)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench of the transport stream packet header parser.
`timescale 1ns / 1ps

module tb_top;
  import tsp_pkg::*;

  localparam logic [PidW-1:0]   PesPid   = 13'h0100;
  localparam logic [PidW-1:0]   PsiPid   = 13'h0101;
  localparam logic [PidW-1:0]   OddPid   = 13'h0102;
  localparam logic [PidW-1:0]   SparePid = 13'h0103;
  localparam logic [ClassW-1:0] ClsOdd   = 2'd3;
  localparam int HoldCycles = 400;
  localparam int NumItems   = 800;

  typedef enum int {
    FillRandom,
    FillZeros,
    FillOnes
  } fill_e;

  // Predicts the parser output and checks results in order.
  class ts_result_board;
    bit [ClassW-1:0] pid_class [PidCount];
    bit [7:0]        pos;
    bit [PidW-1:0]   pid;
    bit [7:0]        hdr;
    bit [7:0]        skip;
    bit [7:0]        pay_len;
    route_e          route = RouteDrop;
    bit              discard, tei, pusi, warn, in_body;
    out_item_t       pending_results [$];
    int              errors;
    int              n_checked;
    int              kind_seen [4];

    function void emit(kind_e k, bit [7:0] data, bit last);
      out_item_t e;
      e.kind            = k;
      e.packet_pid      = pid;
      e.unit_start      = pusi;
      e.error_flag      = tei;
      e.scramble_bits   = hdr[7:6];
      e.field_control   = hdr[5:4];
      e.continuity      = hdr[3:0];
      e.payload_length  = pay_len;
      e.route           = route;
      e.control_warning = warn;
      e.payload_byte    = data;
      e.last_of_packet  = last;
      pending_results.push_back(e);
    endfunction

    function void close_header();
      bit [ClassW-1:0] cls;
      cls = pid_class[pid];
      if (pid == PidNull) route = RouteDrop;
      else if (cls == ClsPsi) route = RoutePsi;
      else if (cls == ClsPes) route = RoutePes;
      else if (pid == PidPat || pid == PidCat || pid == PidTsdt || pid == PidSdt) begin
        route = RoutePsi;
      end else route = RouteDrop;
      warn = (cls == ClsPes) && (hdr[5:4] == AfcNone || hdr[5:4] == AfcBoth);
      in_body = 1'b1;
    endfunction

    function void parse_input(in_item_t it);
      bit [7:0] b;
      bit [7:0] at;
      bit       done;
      if (it.command == CmdTable) begin
        pid_class[it.table_pid] = it.table_class;
        return;
      end
      b  = it.stream_byte;
      at = pos;
      if (at == 0) begin
        pid = '0; hdr = '0; skip = '0; route = RouteDrop;
        tei = 0; pusi = 0; warn = 0; pay_len = '0; in_body = 0; discard = 0;
        if (b != SyncByte) begin
          emit(KindBadSync, 8'h00, 1'b0);
          discard = 1'b1;
        end
      end else if (!discard) begin
        if (at == PosFlags) begin
          tei  = b[7];
          pusi = b[6];
          pid  = {b[4:0], 8'h00};
        end else if (at == PosPidLow) begin
          pid[7:0] = b;
          if (pid == PidPat || pid == PidCat || pid == PidTsdt || pid == PidIpmp ||
              pid == PidSdt) pid_class[pid] = ClsPsi;
        end else if (at == PosCtrl) begin
          hdr = b;
          if (b[5:4] == AfcNone || b[5:4] == AfcPayload) begin
            pay_len = (b[5:4] == AfcPayload) ? FullPayload : 8'd0;
            close_header();
            emit(KindHeader, 8'h00, 1'b0);
          end
        end else if (!in_body) begin
          done = 1'b0;
          if (at == PosAdaptLen) begin
            if (b > MaxAdaptLen) begin
              emit(KindBadAdapt, 8'h00, 1'b0);
              discard = 1'b1;
            end else if (b == 0) done = 1'b1;
            else skip = b;
          end else begin
            if (skip > 0) skip--;
            if (skip == 0) done = 1'b1;
          end
          if (done) begin
            pay_len = (hdr[5:4] == AfcBoth && at < LastPos) ? LastPos - at : 8'd0;
            close_header();
            emit(KindHeader, 8'h00, 1'b0);
          end
        end else if (pay_len > 0) begin
          emit(KindPayload, b, at == LastPos);
        end
      end
      pos = (at >= LastPos) ? 8'd0 : at + 8'd1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task cmp(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s = %0h, expected %0h", n_checked, field, got, want));
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result, kind %0d pid %0h", got.kind, got.packet_pid));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      kind_seen[want.kind]++;
      cmp("kind", 16'(got.kind), 16'(want.kind));
      cmp("packet_pid", 16'(got.packet_pid), 16'(want.packet_pid));
      cmp("unit_start", 16'(got.unit_start), 16'(want.unit_start));
      cmp("error_flag", 16'(got.error_flag), 16'(want.error_flag));
      cmp("scramble_bits", 16'(got.scramble_bits), 16'(want.scramble_bits));
      cmp("field_control", 16'(got.field_control), 16'(want.field_control));
      cmp("continuity", 16'(got.continuity), 16'(want.continuity));
      cmp("payload_length", 16'(got.payload_length), 16'(want.payload_length));
      cmp("route", 16'(got.route), 16'(want.route));
      cmp("control_warning", 16'(got.control_warning), 16'(want.control_warning));
      cmp("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      cmp("last_of_packet", 16'(got.last_of_packet), 16'(want.last_of_packet));
    endtask
  endclass

  logic clk;
  logic rst_n;

  tsp_in_if  in_if ();
  tsp_out_if out_if ();

  ts_packet_header_parser u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ts_result_board sb;
  int  burst_left;
  int  n_sent;
  int  n_writes;
  int  n_packets;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Sink side: random stall modes, plus one long hold-off on request.
  initial begin
    int mode;
    int phase;
    phase = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (phase == 0) begin
          mode  = $urandom_range(0, 3);
          phase = $urandom_range(16, 96);
        end
        phase--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [PidW-1:0] pick_pid();
    case ($urandom_range(0, 11))
      0: return PidPat;
      1: return PidCat;
      2: return PidTsdt;
      3: return PidIpmp;
      4: return PidSdt;
      5: return PidNull;
      6: return PesPid;
      7: return PsiPid;
      8: return OddPid;
      9: return SparePid;
      default: return PidW'($urandom_range(0, PidCount - 1));
    endcase
  endfunction

  task automatic push(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 60);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.parse_input(it);
    n_sent++;
  endtask

  task automatic write_class(input logic [PidW-1:0] pid, input logic [ClassW-1:0] cls);
    in_item_t it;
    it.command     = CmdTable;
    it.stream_byte = 8'($urandom);
    it.table_pid   = pid;
    it.table_class = cls;
    push(it);
    n_writes++;
  endtask

  // One 188-byte packet; wr_pct is the chance of a table write before each byte.
  task automatic send_packet(input logic [7:0] sync, input logic tei, input logic pusi,
                             input logic [PidW-1:0] pid, input logic [7:0] ctrl,
                             input logic [7:0] adapt, input fill_e fill, input int wr_pct);
    in_item_t it;
    logic [7:0] b;
    for (int i = 0; i < PacketBytes; i++) begin
      if (i == 0) b = sync;
      else if (i == PosFlags) b = {tei, pusi, 1'($urandom), pid[12:8]};
      else if (i == PosPidLow) b = pid[7:0];
      else if (i == PosCtrl) b = ctrl;
      else if (i == PosAdaptLen && ctrl[5]) b = adapt;
      else if (fill == FillZeros) b = 8'h00;
      else if (fill == FillOnes) b = 8'hff;
      else b = 8'($urandom);
      if ($urandom_range(0, 99) < wr_pct) begin
        write_class(pick_pid(), ClassW'($urandom_range(0, 3)));
      end
      it.command     = CmdByte;
      it.stream_byte = b;
      it.table_pid   = PidW'($urandom);
      it.table_class = ClassW'($urandom);
      push(it);
    end
    n_packets++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  initial begin
    int r;
    logic [7:0] adapt;
    sb         = new();
    burst_left = 0;
    hold_req   = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_class(PesPid, ClsPes);
    write_class(PsiPid, ClsPsi);
    write_class(OddPid, ClsOdd);
    write_class(PidNull, ClsPes);
    write_class(PidPat, ClsUnknown);
    send_packet(8'h00, 0, 0, PidPat, {2'd0, AfcPayload, 4'd0}, 8'd0, FillOnes, 0);
    send_packet(SyncByte, 0, 1, PesPid, {2'd1, AfcBoth, 4'd5}, 8'd0, FillRandom, 5);
    send_packet(SyncByte, 1, 1, 13'h1234, {2'd3, AfcField, 4'd7}, 8'hff, FillZeros, 0);
    wait_drained();

    hold_req = 1'b1;
    while (n_sent + PacketBytes <= NumItems) begin
      r = $urandom_range(0, 19);
      if (r < 3) adapt = 8'($urandom_range(184, 255));
      else if (r == 3) adapt = 8'd0;
      else if (r == 4) adapt = MaxAdaptLen;
      else if (r < 10) adapt = 8'($urandom_range(0, 183));
      else adapt = 8'($urandom_range(0, 30));
      send_packet(($urandom_range(0, 9) == 0) ? 8'($urandom) : SyncByte,
                  1'($urandom), 1'($urandom), pick_pid(), 8'($urandom), adapt,
                  FillRandom, 3);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d packets with %0d table writes; checked %0d results", n_packets,
             n_writes, sb.n_checked);
    $display("(%0d payload, %0d header, %0d bad sync, %0d bad adaptation), %0d mismatches",
             sb.kind_seen[KindPayload], sb.kind_seen[KindHeader], sb.kind_seen[KindBadSync],
             sb.kind_seen[KindBadAdapt], sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tsp_pkg.sv
hdl/tsp_in_if.sv
hdl/tsp_out_if.sv
hdl/tsp_ram.sv
hdl/ts_packet_header_parser.sv
tb/sv/tb_top.sv
